FILE: rtl/bfa_pkg.sv
// Shared definitions for the bitmap first-fit block allocator.
// Holds the request operation codes and the fixed field widths.
// No dependencies; bfa_if, the allocator top level and the checker use this package.
`default_nettype none

package bfa_pkg;

	localparam int OP_W = 2;
	localparam int IDX_W = 16;
	localparam int IDX_SPAN = 65536;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY = 2'd0,
		OP_ALLOC = 2'd1,
		OP_MARK  = 2'd2,
		OP_FREE  = 2'd3
	} op_t;

endpackage

`default_nettype wire

FILE: rtl/bfa_if.sv
// Valid/ready channel interfaces for the allocator's request and response beats.
// Depends on bfa_pkg for the field widths.
`default_nettype none

interface bfa_req_if;
	logic                       valid;
	logic                       ready;
	logic [bfa_pkg::OP_W-1:0]   op;
	logic [bfa_pkg::IDX_W-1:0]  block_index;

	modport source (output valid, output op, output block_index, input ready);
	modport sink (input valid, input op, input block_index, output ready);
endinterface

interface bfa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [bfa_pkg::IDX_W-1:0]  allocated_index;
	logic                       bit_value;

	modport source (output valid, output found, output allocated_index, output bit_value,
		input ready);
	modport sink (input valid, input found, input allocated_index, input bit_value,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/bfa_map_ram.sv
// Word-wide storage for the used/free map, one write and one read port.
// The read data is registered. No dependencies.
`default_nettype none

module bfa_map_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/bfa_ffs.sv
// Find-first-set unit: returns the position of the lowest set bit of a map word.
// Used once per scanned word during allocation. No dependencies.
`default_nettype none

module bfa_ffs #(
	parameter int WIDTH = 32,
	parameter int IW = 5
) (
	input  wire logic [WIDTH-1:0] vec,
	output logic                  hit,
	output logic      [IW-1:0]    idx
);

	always_comb begin
		hit = |vec;
		idx = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IW'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bitmap_first_fit_block_allocator.sv
// Query, mark and free read the map word, pass the read-modify-write and done states,
// then load the response register; allocate scans from map word zero, stopping at the first free bit,
// up to word SCAN_WORDS - 1, one map word read and searched per cycle by the single find-first unit.
// One request is handled at a time; the next request is taken once the result is
// in the output register. After reset the map memory is cleared one word per cycle
// (DEPTH words, 2048 by default) before the first request is taken.
`default_nettype none

module bitmap_first_fit_block_allocator #(
	parameter int NUM_BLOCKS = 65536,
	parameter int WORD_BITS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bfa_req_if.sink    req,
	bfa_rsp_if.source  rsp
);

	// WORD_BITS must be a power of two (not checked) so a block number splits into word and bit.
	localparam int SCAN_LIMIT = (NUM_BLOCKS < bfa_pkg::IDX_SPAN) ? NUM_BLOCKS :
		bfa_pkg::IDX_SPAN;
	localparam int DEPTH = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int SCAN_WORDS = (SCAN_LIMIT + WORD_BITS - 1) / WORD_BITS;
	localparam int LAST_BITS = SCAN_LIMIT - (SCAN_WORDS - 1) * WORD_BITS;
	localparam int EXT_W = ($clog2(NUM_BLOCKS) + 1 > bfa_pkg::IDX_W) ?
		$clog2(NUM_BLOCKS) + 1 : bfa_pkg::IDX_W + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(SCAN_WORDS - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
	localparam logic [WORD_BITS-1:0] TAIL_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RMW   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [bfa_pkg::OP_W-1:0] op_q;
	logic [BW-1:0] bitpos_q;
	logic [AW-1:0] waddr_q;
	logic inmap_q;
	logic res_found_q;
	logic [bfa_pkg::IDX_W-1:0] res_idx_q;
	logic res_bit_q;
	logic rsp_valid_q;
	logic rsp_found_q;
	logic [bfa_pkg::IDX_W-1:0] rsp_idx_q;
	logic rsp_bit_q;

	logic accept;
	logic load_out;
	logic [EXT_W-1:0] blk_ext;
	logic in_map;
	logic [AW-1:0] word_in;
	logic [WORD_BITS-1:0] bit_onehot;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] free_vec;
	logic ffs_hit;
	logic [BW-1:0] ffs_idx;
	logic [WORD_BITS-1:0] ffs_onehot;

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid & req.ready;
	assign load_out = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign blk_ext = EXT_W'(req.block_index);
	assign in_map = blk_ext < EXT_W'(NUM_BLOCKS);
	assign word_in = AW'(blk_ext >> BW);
	assign bit_onehot = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bitpos_q;
	assign ffs_onehot = {{(WORD_BITS - 1){1'b0}}, 1'b1} << ffs_idx;
	assign free_vec = ~ram_rdata & ((waddr_q == LAST_ADDR) ? TAIL_MASK : {WORD_BITS{1'b1}});

	bfa_ffs #(
		.WIDTH(WORD_BITS),
		.IW(BW)
	) u_ffs (
		.vec(free_vec),
		.hit(ffs_hit),
		.idx(ffs_idx)
	);

	bfa_map_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_raddr = waddr_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = (req.op == bfa_pkg::OP_ALLOC) ? '0 : word_in;
			end
			ST_SCAN: begin
				ram_raddr = AW'(waddr_q + 1'b1);
			end
			default: begin
				ram_raddr = waddr_q;
			end
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = waddr_q;
		ram_wdata = ram_rdata;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_RMW: begin
				if (inmap_q && op_q == bfa_pkg::OP_MARK) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata | bit_onehot;
				end else if (inmap_q && op_q == bfa_pkg::OP_FREE) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata & ~bit_onehot;
				end
			end
			ST_SCAN: begin
				if (ffs_hit) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata | ffs_onehot;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.op == bfa_pkg::OP_ALLOC) ? ST_SCAN : ST_RMW;
					end
				end
				ST_RMW: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (ffs_hit || waddr_q == LAST_ADDR) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= req.op;
					bitpos_q <= req.block_index[BW-1:0];
					inmap_q <= in_map;
					waddr_q <= (req.op == bfa_pkg::OP_ALLOC) ? '0 : word_in;
				end
			end
			ST_RMW: begin
				res_found_q <= 1'b1;
				res_idx_q <= '0;
				if (op_q == bfa_pkg::OP_QUERY) begin
					res_bit_q <= inmap_q ? ram_rdata[bitpos_q] : 1'b1;
				end else begin
					res_bit_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				res_bit_q <= 1'b0;
				if (ffs_hit) begin
					res_found_q <= 1'b1;
					res_idx_q <= bfa_pkg::IDX_W'({waddr_q, ffs_idx});
				end else begin
					res_found_q <= 1'b0;
					res_idx_q <= '0;
					waddr_q <= AW'(waddr_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			rsp_found_q <= res_found_q;
			rsp_idx_q <= res_idx_q;
			rsp_bit_q <= res_bit_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.found = rsp_found_q;
	assign rsp.allocated_index = rsp_idx_q;
	assign rsp.bit_value = rsp_bit_q;

endmodule

`default_nettype wire

FILE: rtl/bfa_checker.sv
// Port-level checks for the allocator and the bind that attaches them to the top level.
// Depends on bfa_pkg for field widths and on bitmap_first_fit_block_allocator.
`default_nettype none

module bfa_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic                       rsp_found,
	input wire logic [bfa_pkg::IDX_W-1:0]  rsp_allocated_index,
	input wire logic                       rsp_bit_value
);

	// A stalled response beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
		$stable(rsp_allocated_index) && $stable(rsp_bit_value))
		else $error("response beat changed while stalled");

	// The block works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in progress");

	// A failed allocation reports block zero and no query bit.
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_allocated_index == '0 && !rsp_bit_value)
		else $error("failed allocation carries stray fields");

	// A nonzero block number only comes from a successful allocation.
	a_alloc_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_allocated_index != '0 |-> rsp_found && !rsp_bit_value)
		else $error("allocation result mixed with query result");

endmodule

bind bitmap_first_fit_block_allocator bfa_checker u_bfa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_found(rsp.found),
	.rsp_allocated_index(rsp.allocated_index),
	.rsp_bit_value(rsp.bit_value)
);

`default_nettype wire
